// ===== sv/dpe_pkg.sv =====
// Package for the divisor pair enumerator: widths, microcode format and program ROM.
`default_nettype none
package dpe_pkg;

	localparam int IN_W      = 12;
	localparam int OUT_W     = 12;
	localparam int NUM_WIDTH = 12;
	localparam int CAND_W    = (NUM_WIDTH + 1) / 2 + 1;
	localparam int SQ_W      = 2 * CAND_W;
	localparam int CNT_W     = $clog2(NUM_WIDTH + 1);
	localparam int STEP_W    = 4;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV_START,
		OP_DIV_WAIT,
		OP_PUSH_CAND,
		OP_PUSH_Q,
		OP_PUSH_ZERO,
		OP_INC,
		OP_FLUSH
	} op_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_ALWAYS,
		COND_N_ZERO,
		COND_SQ_GT,
		COND_REM_NZ,
		COND_Q_EQ
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	localparam step_t ST_LOAD  = 4'd0;
	localparam step_t ST_TEST  = 4'd2;
	localparam step_t ST_INC   = 4'd7;
	localparam step_t ST_FLUSH = 4'd8;
	localparam step_t ST_ZERO  = 4'd9;

	// Program: load, trial loop over candidates, flush the held result with last set.
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		case (step)
			4'd0: w = '{OP_LOAD,      COND_NONE,   ST_LOAD};
			4'd1: w = '{OP_NOP,       COND_N_ZERO, ST_ZERO};
			4'd2: w = '{OP_DIV_START, COND_SQ_GT,  ST_FLUSH};
			4'd3: w = '{OP_DIV_WAIT,  COND_NONE,   ST_LOAD};
			4'd4: w = '{OP_NOP,       COND_REM_NZ, ST_INC};
			4'd5: w = '{OP_PUSH_CAND, COND_Q_EQ,   ST_INC};
			4'd6: w = '{OP_PUSH_Q,    COND_NONE,   ST_LOAD};
			4'd7: w = '{OP_INC,       COND_ALWAYS, ST_TEST};
			4'd8: w = '{OP_FLUSH,     COND_ALWAYS, ST_LOAD};
			4'd9: w = '{OP_PUSH_ZERO, COND_ALWAYS, ST_FLUSH};
			default: w = '{OP_NOP,    COND_ALWAYS, ST_LOAD};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== sv/dpe_div.sv =====
// Restoring divider: NUM_WIDTH-bit dividend by candidate, one quotient bit per cycle.
`default_nettype none
module dpe_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [dpe_pkg::NUM_WIDTH-1:0] dividend,
	input  wire logic [dpe_pkg::CAND_W-1:0]    divisor,
	output logic                               busy,
	output logic [dpe_pkg::NUM_WIDTH-1:0]      quotient,
	output logic [dpe_pkg::CAND_W-1:0]         remainder
);
	import dpe_pkg::*;

	logic [CNT_W-1:0]     cnt_q;
	logic [NUM_WIDTH-1:0] quo_q;
	logic [CAND_W-1:0]    rem_q;
	logic [CAND_W-1:0]    dsr_q;
	logic [CAND_W:0]      trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[NUM_WIDTH-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_WIDTH);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			// remainder stays below the divisor, so it fits CAND_W bits
			rem_q <= fits ? CAND_W'(trial - {1'b0, dsr_q}) : trial[CAND_W-1:0];
			quo_q <= {quo_q[NUM_WIDTH-2:0], fits};
		end
	end

	assign busy      = cnt_q != '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

// ===== sv/divisor_pair_enumerator_top.sv =====
// Divisor pair enumerator: microcoded trial-division sequencer with output register.
//
// Input channel (number, in_valid/in_ready) takes one number; the output channel
// (divisor_value, last, out_valid/out_ready) returns every divisor of it, each
// small divisor followed by its cofactor (a square root only once), last set
// on the final one. A zero input gives a single 0 with last set.
// One item is worked at a time: in_ready is high only while the sequencer sits
// at its load step. Each candidate from 1 up to the integer square root passes
// through the start, wait, test and increment steps of the bit-serial divider
// loop; each divisor found adds one push step.
// The first result appears after the second divisor is found (or at the end),
// since a found divisor is held one place back until it is known whether it is
// the final one.
// Reset clears the step counter, output valid and held-result flag; the block
// is then ready for a number. A stalled receiver makes the output register hold
// its result; a flush, or a push with a result held, waits until it frees.
`default_nettype none
module divisor_pair_enumerator_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [dpe_pkg::IN_W-1:0]  number,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	output logic [dpe_pkg::OUT_W-1:0]      divisor_value,
	output logic                           last,
	output logic                           out_valid,
	input  wire logic                      out_ready
);
	import dpe_pkg::*;

	step_t                step_q, step_nxt;
	ucode_t               uw;
	logic [NUM_WIDTH-1:0] num_q;
	logic [CAND_W-1:0]    cand_q;
	logic [NUM_WIDTH-1:0] pend_val_q;
	logic                 pend_vld_q;
	logic [OUT_W-1:0]     out_val_q;
	logic                 out_last_q;
	logic                 out_vld_q;

	logic                 div_busy;
	logic [NUM_WIDTH-1:0] div_quo;
	logic [CAND_W-1:0]    div_rem;
	logic                 div_start;

	logic                 out_free;
	logic                 is_push;
	logic                 stall;
	logic                 cond_hit;
	logic [SQ_W-1:0]      cand_sq;
	logic [NUM_WIDTH-1:0] push_val;

	assign uw       = ucode_rom(step_q);
	assign out_free = !out_vld_q || out_ready;
	assign cand_sq  = SQ_W'(cand_q) * SQ_W'(cand_q);
	assign is_push  = (uw.op == OP_PUSH_CAND) || (uw.op == OP_PUSH_Q) ||
	                  (uw.op == OP_PUSH_ZERO);

	always_comb begin
		case (uw.op)
			OP_PUSH_CAND: push_val = NUM_WIDTH'(cand_q);
			OP_PUSH_Q:    push_val = div_quo;
			default:      push_val = '0;
		endcase
	end

	always_comb begin
		case (uw.op)
			OP_LOAD:     stall = !in_valid;
			OP_DIV_WAIT: stall = div_busy;
			OP_FLUSH:    stall = !out_free;
			OP_PUSH_CAND, OP_PUSH_Q, OP_PUSH_ZERO:
			             stall = pend_vld_q && !out_free;
			default:     stall = 1'b0;
		endcase
	end

	always_comb begin
		case (uw.cond)
			COND_ALWAYS: cond_hit = 1'b1;
			COND_N_ZERO: cond_hit = num_q == '0;
			COND_SQ_GT:  cond_hit = cand_sq > SQ_W'(num_q);
			COND_REM_NZ: cond_hit = div_rem != '0;
			COND_Q_EQ:   cond_hit = div_quo == NUM_WIDTH'(cand_q);
			default:     cond_hit = 1'b0;
		endcase
	end

	always_comb begin
		if (stall) begin
			step_nxt = step_q;
		end else if (cond_hit) begin
			step_nxt = uw.target;
		end else begin
			step_nxt = step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_LOAD;
		end else begin
			step_q <= step_nxt;
		end
	end

	assign div_start = (uw.op == OP_DIV_START);

	dpe_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (num_q),
		.divisor   (cand_q),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		if (uw.op == OP_LOAD && in_valid) begin
			num_q  <= number[NUM_WIDTH-1:0];
			cand_q <= CAND_W'(1);
		end else if (uw.op == OP_INC) begin
			cand_q <= cand_q + 1'b1;
		end
		if (is_push && !stall) begin
			pend_val_q <= push_val;
		end
	end

	// output register; a new push moves the held result out with last clear, a flush with last set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (is_push && !stall) begin
				pend_vld_q <= 1'b1;
				if (pend_vld_q) begin
					out_vld_q <= 1'b1;
				end
			end else if (uw.op == OP_FLUSH && !stall) begin
				pend_vld_q <= 1'b0;
				out_vld_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_push && !stall && pend_vld_q) begin
			out_val_q  <= OUT_W'(pend_val_q);
			out_last_q <= 1'b0;
		end else if (uw.op == OP_FLUSH && !stall) begin
			out_val_q  <= OUT_W'(pend_val_q);
			out_last_q <= 1'b1;
		end
	end

	assign in_ready      = (uw.op == OP_LOAD);
	assign out_valid     = out_vld_q;
	assign divisor_value = out_val_q;
	assign last          = out_last_q;

endmodule
`default_nettype wire

// ===== sv/dpe_checker.sv =====
// Port-level checker for the divisor pair enumerator, bound to the top level.
`default_nettype none
module dpe_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic [dpe_pkg::IN_W-1:0] number,
	input wire logic                     in_valid,
	input wire logic                     in_ready,
	input wire logic [dpe_pkg::OUT_W-1:0] divisor_value,
	input wire logic                     last,
	input wire logic                     out_valid,
	input wire logic                     out_ready
);
	import dpe_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(divisor_value) && $stable(last))
		else $error("stalled result changed");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after an accepted item");

	// a mid-item result never shows while a new number is taken
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("ready while item results remain");

	// zero only comes alone, for a zero input
	a_zero_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divisor_value == '0 |-> last)
		else $error("zero divisor without last");

endmodule

bind divisor_pair_enumerator_top dpe_checker u_dpe_checker (.*);
`default_nettype wire
